// File: hw/rtl/buddy_page_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Check a property on the rising clock edge; skip it while reset is asserted.
`define BPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on the rising clock edge; skip it while reset is asserted.
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/bpa_pkg.sv
// Shared constants, types and helper functions of the buddy page allocator.
package bpa_pkg;

  localparam int unsigned MaxOrder  = 10;
  localparam int unsigned PoolPages = 4096;
  localparam int unsigned SlotCount = 2 * PoolPages;
  localparam int unsigned PageW     = $clog2(PoolPages);
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned OrdW      = 4;
  localparam int unsigned CountW    = 13;

  localparam logic [OrdW-1:0] MaxOrd = OrdW'(MaxOrder);
  localparam logic [OrdW-1:0] NoOrd  = OrdW'(MaxOrder + 1);

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NONE  = 2'd3
  } bpa_kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MEM   = 2'd1,
    STAT_ZERO_REQ = 2'd2,
    STAT_BAD_FREE = 2'd3
  } bpa_status_e;

  localparam logic CfgZonePages = 1'b0;
  localparam logic CfgBasePage  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_CHECK,
    ST_A_RD,
    ST_A_TST,
    ST_A_MARK,
    ST_A_SPL1,
    ST_A_SPL2,
    ST_A_FIN,
    ST_F_CHECK,
    ST_F_ORD,
    ST_F_CLR,
    ST_F_TST,
    ST_F_SET,
    ST_F_FIN,
    ST_DONE
  } bpa_state_e;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    logic             wdata;
  } bpa_bit_req_t;

  typedef struct packed {
    logic             we;
    logic [PageW-1:0] addr;
    logic [OrdW-1:0]  wdata;
  } bpa_ord_req_t;

  // Flat bitmap slot of a unit: order o starts after all finer orders.
  function automatic logic [SlotW-1:0] slot_addr(logic [OrdW-1:0] o, logic [PageW-1:0] u);
    logic [SlotW:0] off;
    off = (SlotW+1)'(SlotCount) - ((SlotW+1)'(SlotCount) >> o);
    return off[SlotW-1:0] + SlotW'(u);
  endfunction

  // Smallest order whose block holds req pages (req nonzero).
  function automatic logic [4:0] ceil_order(logic [15:0] req);
    logic [15:0] m;
    logic [4:0]  r;
    m = req - 16'd1;
    r = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (m[i]) r = 5'(i + 1);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bpa_bit_ram.sv
// Unit bitmap store of all orders: one write and one registered read a cycle.
module bpa_bit_ram (
  input  logic                 clk_i,
  input  bpa_pkg::bpa_bit_req_t req_i,
  output logic                 rdata_o
);

  logic mem [bpa_pkg::SlotCount];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.addr] <= req_i.wdata;
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bpa_ord_ram.sv
// Per-page block order store: one write and one registered read a cycle.
module bpa_ord_ram (
  input  logic                         clk_i,
  input  bpa_pkg::bpa_ord_req_t        req_i,
  output logic [bpa_pkg::OrdW-1:0]     rdata_o
);

  logic [bpa_pkg::OrdW-1:0] mem [bpa_pkg::PoolPages];
  logic [bpa_pkg::OrdW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.addr] <= req_i.wdata;
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/buddy_page_allocator.sv
// Buddy page allocator top level: request sequencer, zone registers and result register.
// Init runs the clearing sweep; allocate probes the units of each order in turn, skipping
// orders without units, then splits level by level; free reads the block order, then merges.
// One request at a time, the next taken in the idle state after the result is
// loaded; a full result register holds the sequencer. Reset runs the clearing sweep
// (zone of 4096 pages at page 0); configuration writes are taken at any time.
`include "buddy_page_allocator_assert.svh"

module buddy_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [39:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [15:0] request_pages, [56:16] page_number
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [40:0] granted_page, [53:41] pages_free
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned PW = bpa_pkg::PageW;
  localparam int unsigned CW = bpa_pkg::CountW;
  localparam int unsigned OW = bpa_pkg::OrdW;

  // Configuration registers; they only take effect at the next init.
  logic [CW-1:0] zone_q;
  logic [39:0]   base_q;

  // Live zone, latched by init.
  logic [CW-1:0] live_q, live_d;
  logic [39:0]   lbase_q, lbase_d;
  logic [CW-1:0] free_q, free_d;

  bpa_pkg::bpa_state_e state_q, state_d;
  logic          pend_q, pend_d;    // init request waits for its result
  logic [OW-1:0] ord_q, ord_d;      // current order of the walk
  logic [OW-1:0] tgt_q, tgt_d;      // requested or freed block order
  logic [PW-1:0] unit_q, unit_d;
  logic [PW-1:0] idx_q, idx_d;
  logic [15:0]   req_q, req_d;
  logic [40:0]   page_q, page_d;
  logic [1:0]    st_q, st_d;
  logic [40:0]   gr_q, gr_d;

  // Result register.
  logic          ov_q, ov_d;
  logic [1:0]    ost_q, ost_d;
  logic [40:0]   ogr_q, ogr_d;
  logic [CW-1:0] ofree_q, ofree_d;

  bpa_pkg::bpa_bit_req_t bit_req;
  bpa_pkg::bpa_ord_req_t ord_req;
  logic                  bit_rd;
  logic [OW-1:0]         ord_rd;

  logic [OW-1:0] b_ord;
  logic [PW-1:0] b_unit;

  logic [CW-1:0] units;       // units present at ord_q in the live zone
  logic [PW-1:0] unit_last;   // last unit of ord_q in the whole pool
  logic [PW-1:0] buddy;
  logic [4:0]    need;
  logic [41:0]   rel;
  logic          greedy_free;
  logic          accept;

  bpa_bit_ram u_bit_ram (.clk_i(clk_i), .req_i(bit_req), .rdata_o(bit_rd));
  bpa_ord_ram u_ord_ram (.clk_i(clk_i), .req_i(ord_req), .rdata_o(ord_rd));

  assign units     = live_q >> ord_q;
  assign unit_last = PW'((bpa_pkg::PoolPages >> ord_q) - 1);
  assign buddy     = unit_q ^ PW'(1);
  assign need      = bpa_pkg::ceil_order(req_q);
  assign rel       = {1'b0, page_q} - {2'b0, lbase_q};
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;

  // Greedy layout: top order holds whole blocks from page 0, below it at most one block
  // per order, right after everything coarser.
  always_comb begin
    if (ord_q == bpa_pkg::MaxOrd) begin
      greedy_free = {1'b0, unit_q} < units;
    end else begin
      greedy_free = live_q[ord_q] &&
                    ({1'b0, unit_q} == ((live_q >> (ord_q + OW'(1))) << 1));
    end
  end

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    live_d  = live_q;
    lbase_d = lbase_q;
    free_d  = free_q;
    ord_d   = ord_q;
    tgt_d   = tgt_q;
    unit_d  = unit_q;
    idx_d   = idx_q;
    req_d   = req_q;
    page_d  = page_q;
    st_d    = st_q;
    gr_d    = gr_q;
    ov_d    = ov_q && !m_axis_tready_i;
    ost_d   = ost_q;
    ogr_d   = ogr_q;
    ofree_d = ofree_q;

    b_ord         = ord_q;
    b_unit        = unit_q;
    bit_req.we    = 1'b0;
    bit_req.wdata = 1'b0;
    ord_req.we    = 1'b0;
    ord_req.addr  = unit_q;
    ord_req.wdata = bpa_pkg::NoOrd;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      bpa_pkg::ST_CLEAR: begin
        // Sweep every unit of every order; the order-0 pass also wipes block orders.
        bit_req.we    = 1'b1;
        bit_req.wdata = !greedy_free;
        ord_req.we    = (ord_q == '0);
        if (unit_q == unit_last) begin
          unit_d = '0;
          if (ord_q == bpa_pkg::MaxOrd) begin
            state_d = pend_q ? bpa_pkg::ST_DONE : bpa_pkg::ST_IDLE;
            pend_d  = 1'b0;
          end else begin
            ord_d = ord_q + OW'(1);
          end
        end else begin
          unit_d = unit_q + PW'(1);
        end
      end
      bpa_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          req_d  = s_axis_tdata_i[15:0];
          page_d = s_axis_tdata_i[56:16];
          st_d   = bpa_pkg::STAT_OK;
          gr_d   = '0;
          unique case (s_axis_tuser_i)
            bpa_pkg::KIND_INIT: begin
              live_d  = (zone_q > CW'(bpa_pkg::PoolPages)) ? CW'(bpa_pkg::PoolPages) : zone_q;
              lbase_d = base_q;
              free_d  = live_d;
              ord_d   = '0;
              unit_d  = '0;
              pend_d  = 1'b1;
              state_d = bpa_pkg::ST_CLEAR;
            end
            bpa_pkg::KIND_ALLOC: state_d = bpa_pkg::ST_A_CHECK;
            bpa_pkg::KIND_FREE:  state_d = bpa_pkg::ST_F_CHECK;
            default:             state_d = bpa_pkg::ST_DONE;
          endcase
        end
      end
      bpa_pkg::ST_A_CHECK: begin
        ord_d  = need[OW-1:0];
        tgt_d  = need[OW-1:0];
        unit_d = '0;
        if (req_q == '0) begin
          st_d    = bpa_pkg::STAT_ZERO_REQ;
          state_d = bpa_pkg::ST_DONE;
        end else if (req_q > 16'(free_q) || need > 5'(bpa_pkg::MaxOrder)) begin
          st_d    = bpa_pkg::STAT_NO_MEM;
          state_d = bpa_pkg::ST_DONE;
        end else begin
          state_d = bpa_pkg::ST_A_RD;
        end
      end
      bpa_pkg::ST_A_RD: begin
        // Skip orders without any unit, otherwise issue the probe.
        if (units == '0) begin
          if (ord_q == bpa_pkg::MaxOrd) begin
            st_d    = bpa_pkg::STAT_NO_MEM;
            state_d = bpa_pkg::ST_DONE;
          end else begin
            ord_d = ord_q + OW'(1);
          end
        end else begin
          state_d = bpa_pkg::ST_A_TST;
        end
      end
      bpa_pkg::ST_A_TST: begin
        if (!bit_rd) begin
          state_d = bpa_pkg::ST_A_MARK;
        end else if ({1'b0, unit_q} + CW'(1) < units) begin
          unit_d  = unit_q + PW'(1);
          state_d = bpa_pkg::ST_A_RD;
        end else if (ord_q == bpa_pkg::MaxOrd) begin
          st_d    = bpa_pkg::STAT_NO_MEM;
          state_d = bpa_pkg::ST_DONE;
        end else begin
          ord_d   = ord_q + OW'(1);
          unit_d  = '0;
          state_d = bpa_pkg::ST_A_RD;
        end
      end
      bpa_pkg::ST_A_MARK: begin
        bit_req.we    = 1'b1;
        bit_req.wdata = 1'b1;
        state_d = (ord_q == tgt_q) ? bpa_pkg::ST_A_FIN : bpa_pkg::ST_A_SPL1;
      end
      bpa_pkg::ST_A_SPL1: begin
        // Split: mark the lower half used, the upper half goes free next cycle.
        b_ord         = ord_q - OW'(1);
        b_unit        = unit_q << 1;
        bit_req.we    = 1'b1;
        bit_req.wdata = 1'b1;
        ord_d   = b_ord;
        unit_d  = b_unit;
        state_d = bpa_pkg::ST_A_SPL2;
      end
      bpa_pkg::ST_A_SPL2: begin
        b_unit     = unit_q | PW'(1);
        bit_req.we = 1'b1;
        state_d = (ord_q == tgt_q) ? bpa_pkg::ST_A_FIN : bpa_pkg::ST_A_SPL1;
      end
      bpa_pkg::ST_A_FIN: begin
        ord_req.addr  = unit_q << tgt_q;
        ord_req.wdata = tgt_q;
        ord_req.we    = 1'b1;
        free_d  = free_q - (CW'(1) << tgt_q);
        gr_d    = 41'(lbase_q) + 41'(ord_req.addr);
        state_d = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_F_CHECK: begin
        idx_d        = rel[PW-1:0];
        ord_req.addr = rel[PW-1:0];
        if (rel[41] || rel[40:0] >= 41'(live_q)) begin
          st_d    = bpa_pkg::STAT_BAD_FREE;
          state_d = bpa_pkg::ST_DONE;
        end else begin
          state_d = bpa_pkg::ST_F_ORD;
        end
      end
      bpa_pkg::ST_F_ORD: begin
        ord_req.addr = idx_q;
        if (ord_rd > bpa_pkg::MaxOrd) begin
          st_d    = bpa_pkg::STAT_BAD_FREE;
          state_d = bpa_pkg::ST_DONE;
        end else begin
          ord_req.we = 1'b1;
          tgt_d   = ord_rd;
          ord_d   = ord_rd;
          unit_d  = idx_q >> ord_rd;
          state_d = bpa_pkg::ST_F_CLR;
        end
      end
      bpa_pkg::ST_F_CLR: begin
        // Clear the own unit where no merge is possible, else probe the buddy first.
        if (ord_q == bpa_pkg::MaxOrd || {1'b0, buddy} >= units) begin
          bit_req.we = 1'b1;
          state_d    = bpa_pkg::ST_F_FIN;
        end else begin
          b_unit  = buddy;
          state_d = bpa_pkg::ST_F_TST;
        end
      end
      bpa_pkg::ST_F_TST: begin
        // Buddy taken: clear the own unit and stop. Buddy free: mark it, merge upward.
        bit_req.we = 1'b1;
        if (bit_rd) begin
          state_d = bpa_pkg::ST_F_FIN;
        end else begin
          b_unit        = buddy;
          bit_req.wdata = 1'b1;
          state_d       = bpa_pkg::ST_F_SET;
        end
      end
      bpa_pkg::ST_F_SET: begin
        bit_req.we    = 1'b1;
        bit_req.wdata = 1'b1;
        ord_d   = ord_q + OW'(1);
        unit_d  = unit_q >> 1;
        state_d = bpa_pkg::ST_F_CLR;
      end
      bpa_pkg::ST_F_FIN: begin
        free_d  = free_q + (CW'(1) << tgt_q);
        state_d = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_DONE: begin
        // Hand the result over once the result register is free.
        if (!ov_q || m_axis_tready_i) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          ogr_d   = gr_q;
          ofree_d = free_q;
          state_d = bpa_pkg::ST_IDLE;
        end
      end
      default: state_d = bpa_pkg::ST_IDLE;
    endcase

    bit_req.addr = bpa_pkg::slot_addr(b_ord, b_unit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::ST_CLEAR;
      pend_q  <= 1'b0;
      live_q  <= CW'(bpa_pkg::PoolPages);
      lbase_q <= '0;
      free_q  <= CW'(bpa_pkg::PoolPages);
      ord_q   <= '0;
      unit_q  <= '0;
      ov_q    <= 1'b0;
      zone_q  <= CW'(bpa_pkg::PoolPages);
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      ord_q   <= ord_d;
      unit_q  <= unit_d;
      pend_q  <= pend_d;
      live_q  <= live_d;
      lbase_q <= lbase_d;
      free_q  <= free_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == bpa_pkg::CfgZonePages) zone_q <= cfg_data_i[CW-1:0];
        else                                    base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q   <= tgt_d;
    idx_q   <= idx_d;
    req_q   <= req_d;
    page_q  <= page_d;
    st_q    <= st_d;
    gr_q    <= gr_d;
    ost_q   <= ost_d;
    ogr_q   <= ogr_d;
    ofree_q <= ofree_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = ost_q;
  assign m_axis_tdata_o  = {2'b00, ofree_q, ogr_q};

  `BPA_ASSERT(a_free_bound, clk_i, rst_ni, free_q <= live_q, "free count above zone size")
  `BPA_ASSERT_IMP(a_no_req_in_clear, clk_i, rst_ni, state_q == bpa_pkg::ST_CLEAR, !accept, "request taken while clearing")
  `BPA_ASSERT_IMP(a_grant_only_ok, clk_i, rst_ni, ov_q && ost_q != bpa_pkg::STAT_OK, ogr_q == '0, "granted page on failed request")
  `BPA_ASSERT_IMP(a_ord_in_range, clk_i, rst_ni, state_q == bpa_pkg::ST_A_RD || state_q == bpa_pkg::ST_F_CLR, ord_q <= bpa_pkg::MaxOrd, "walk order out of range")

endmodule
